[rtl/armc_pkg.sv]
// Package for the recovery maneuver controller: shared types, codes and constants.
// Used by armc_cfg, armc_core and the top level; depends on nothing.
package armc_pkg;

    // Operation carried by each input item
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Status codes of a result item
    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;
    localparam logic [1:0] ST_IDLE = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_REV_SPEED      = 3'd0;
    localparam logic [2:0] REG_TURN_SPEED     = 3'd1;
    localparam logic [2:0] REG_REAR_CLEARANCE = 3'd2;
    localparam logic [2:0] REG_HALF_LENGTH    = 3'd3;
    localparam logic [2:0] REG_HALF_WIDTH     = 3'd4;
    localparam logic [2:0] REG_MIN_RADIUS     = 3'd5;
    localparam logic [2:0] REG_MAX_TURN_RATE  = 3'd6;
    localparam logic [2:0] REG_TIMEOUT_TICKS  = 3'd7;

    // Register reset values
    localparam logic [9:0]  RST_REV_SPEED      = 10'd120;
    localparam logic [9:0]  RST_TURN_SPEED     = 10'd80;
    localparam logic [10:0] RST_REAR_CLEARANCE = 11'd200;
    localparam logic [10:0] RST_HALF_LENGTH    = 11'd300;
    localparam logic [10:0] RST_HALF_WIDTH     = 11'd230;
    localparam logic [13:0] RST_MIN_RADIUS     = 14'd1038;
    localparam logic [11:0] RST_MAX_TURN_RATE  = 12'd77;
    localparam logic [15:0] RST_TIMEOUT_TICKS  = 16'd300;

    // Maneuver selection thresholds in mm of rear room
    localparam logic [13:0] AVAIL_SIMPLE_MIN = 14'd250;
    localparam logic [13:0] AVAIL_THREE_MIN  = 14'd150;
    // Safe distance clamp; 7/10 of the room reaches the upper bound from this room on
    localparam logic [9:0]  SAFE_MIN         = 10'd100;
    localparam logic [9:0]  SAFE_MAX         = 10'd600;
    localparam logic [13:0] AVAIL_SAFE_SAT   = 14'd858;
    // ceil(2^16 / 10), exact for the 13-bit dividends used here
    localparam logic [12:0] DIV10_RECIP      = 13'd6554;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_SIMPLE = 2'd1,
        MODE_THREE  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        PH_REV_STEER    = 2'd0,
        PH_FWD_STEER    = 2'd1,
        PH_REV_STRAIGHT = 2'd2,
        PH_DONE         = 2'd3
    } t_phase;

    typedef struct packed {
        logic [9:0]  rev_speed;
        logic [9:0]  turn_speed;
        logic [10:0] rear_clearance;
        logic [10:0] half_length;
        logic [10:0] half_width;
        logic [13:0] min_radius;
        logic [11:0] max_turn_rate;
        logic [15:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic        func;
        logic        scan_valid;
        logic [13:0] dist_front;
        logic [13:0] dist_rear;
        logic [13:0] dist_left;
        logic [13:0] dist_right;
    } t_item;

    typedef struct packed {
        t_mode       mode;
        t_phase      turn_phase;
        logic        steer_left;
        logic [9:0]  safe_distance;
        logic [15:0] travel_tenths;
        logic [15:0] elapsed_ticks;
    } t_state;

    typedef struct packed {
        logic [1:0]         status;
        logic               cmd_valid;
        logic signed [10:0] linear_speed;
        logic signed [12:0] turn_rate;
        logic [1:0]         maneuver;
    } t_result;

endpackage

[rtl/armc_cfg.sv]
// Configuration register file of the recovery maneuver controller.
// Depends on armc_pkg for the register indexes, reset values and t_cfg.
module armc_cfg
    import armc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [2:0]  i_wr_index,
    input  logic [15:0] i_wr_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write and mask the data to the register width
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_index)
                REG_REV_SPEED:      n_cfg.rev_speed      = i_wr_data[9:0];
                REG_TURN_SPEED:     n_cfg.turn_speed     = i_wr_data[9:0];
                REG_REAR_CLEARANCE: n_cfg.rear_clearance = i_wr_data[10:0];
                REG_HALF_LENGTH:    n_cfg.half_length    = i_wr_data[10:0];
                REG_HALF_WIDTH:     n_cfg.half_width     = i_wr_data[10:0];
                REG_MIN_RADIUS:     n_cfg.min_radius     = i_wr_data[13:0];
                REG_MAX_TURN_RATE:  n_cfg.max_turn_rate  = i_wr_data[11:0];
                REG_TIMEOUT_TICKS:  n_cfg.timeout_ticks  = i_wr_data;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    // Hold the registers, load defaults on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rev_speed      <= RST_REV_SPEED;
            r_cfg.turn_speed     <= RST_TURN_SPEED;
            r_cfg.rear_clearance <= RST_REAR_CLEARANCE;
            r_cfg.half_length    <= RST_HALF_LENGTH;
            r_cfg.half_width     <= RST_HALF_WIDTH;
            r_cfg.min_radius     <= RST_MIN_RADIUS;
            r_cfg.max_turn_rate  <= RST_MAX_TURN_RATE;
            r_cfg.timeout_ticks  <= RST_TIMEOUT_TICKS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/armc_core.sv]
// Combinational step of the recovery maneuver controller: maneuver planning on a
// start item, sequence advance on a tick item. Depends on armc_pkg.
module armc_core
    import armc_pkg::*;
(
    input  t_item   i_item,
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    output t_state  o_state_next,
    output t_result o_result
);

    logic signed [14:0] avail_s;
    logic               avail_pos;
    logic [13:0]        avail;
    logic [16:0]        need;
    logic [16:0]        side_sum;
    t_mode              choice;
    logic [12:0]        avail7;
    logic [25:0]        div_prod;
    logic [9:0]         tenth7;
    logic [9:0]         safe_new;
    logic [15:0]        elapsed_inc;
    logic               timed_out;
    logic               rear_blocked;
    logic               front_blocked;
    logic [13:0]        safe_x10;
    logic [12:0]        safe_x5;
    logic [11:0]        safe_x3;
    logic [9:0]         move_speed;
    logic [16:0]        travel_sum;
    logic [15:0]        travel_sat;
    logic signed [10:0] neg_backup;
    logic signed [10:0] pos_turn_spd;
    logic signed [10:0] neg_turn_spd;
    logic signed [12:0] rate_s;
    logic signed [12:0] steer_rate;

    // Plan: rear room and the room needed for a straight reverse
    assign avail_s   = $signed({1'b0, i_item.dist_rear}) -
                       $signed({4'b0, i_cfg.rear_clearance});
    assign avail_pos = (avail_s > 15'sd0);
    assign avail     = avail_s[13:0];
    assign need      = {2'b0, i_cfg.min_radius, 1'b0} + {5'b0, i_cfg.half_width, 1'b0};
    assign side_sum  = {3'b0, i_item.dist_left} + {3'b0, i_item.dist_right};

    always_comb begin
        choice = MODE_IDLE;
        if (i_item.scan_valid && avail_pos) begin
            if (avail >= AVAIL_SIMPLE_MIN && side_sum >= need) begin
                choice = MODE_SIMPLE;
            end else if (avail >= AVAIL_THREE_MIN) begin
                choice = MODE_THREE;
            end
        end
    end

    // Safe distance: 7/10 of the room by reciprocal multiply, clamped
    assign avail7   = {avail[9:0], 3'b0} - {3'b0, avail[9:0]};
    assign div_prod = avail7 * DIV10_RECIP;
    assign tenth7   = div_prod[25:16];

    always_comb begin
        if (avail >= AVAIL_SAFE_SAT) begin
            safe_new = SAFE_MAX;
        end else if (tenth7 < SAFE_MIN) begin
            safe_new = SAFE_MIN;
        end else begin
            safe_new = tenth7;
        end
    end

    // Tick: time limit, obstacle checks and travel limits
    assign elapsed_inc   = (i_state.elapsed_ticks == 16'hFFFF) ? i_state.elapsed_ticks
                                                               : i_state.elapsed_ticks + 16'd1;
    assign timed_out     = (elapsed_inc > i_cfg.timeout_ticks);
    assign rear_blocked  = ({3'b0, i_item.dist_rear} < {3'b0, i_cfg.rear_clearance});
    assign front_blocked = (i_item.dist_front <
                            {2'b0, {1'b0, i_cfg.half_length} + {1'b0, i_cfg.rear_clearance}});
    assign safe_x10      = {1'b0, i_state.safe_distance, 3'b0} +
                           {3'b0, i_state.safe_distance, 1'b0};
    assign safe_x5       = {1'b0, i_state.safe_distance, 2'b0} + {3'b0, i_state.safe_distance};
    assign safe_x3       = {1'b0, i_state.safe_distance, 1'b0} + {2'b0, i_state.safe_distance};

    // Travel of one tick equals the commanded speed in tenths of mm, saturated
    assign move_speed = (i_state.mode == MODE_SIMPLE) ? i_cfg.rev_speed : i_cfg.turn_speed;
    assign travel_sum = {1'b0, i_state.travel_tenths} + {7'b0, move_speed};
    assign travel_sat = travel_sum[16] ? 16'hFFFF : travel_sum[15:0];

    // Signed commands
    assign neg_backup   = -$signed({1'b0, i_cfg.rev_speed});
    assign pos_turn_spd = $signed({1'b0, i_cfg.turn_speed});
    assign neg_turn_spd = -pos_turn_spd;
    assign rate_s       = $signed({1'b0, i_cfg.max_turn_rate});
    assign steer_rate   = i_state.steer_left ? rate_s : -rate_s;

    // Next state and result
    always_comb begin
        o_state_next = i_state;
        o_result     = '{status: ST_IDLE, cmd_valid: 1'b0, linear_speed: 11'sd0,
                         turn_rate: 13'sd0, maneuver: 2'd0};
        if (i_item.func == FUNC_START) begin
            if (choice == MODE_IDLE) begin
                o_state_next.mode = MODE_IDLE;
                o_result.status   = ST_FAIL;
            end else begin
                o_state_next.mode          = choice;
                o_state_next.safe_distance = safe_new;
                o_state_next.steer_left    = (i_item.dist_left >= i_item.dist_right);
                o_state_next.travel_tenths = 16'd0;
                o_state_next.turn_phase    = PH_REV_STEER;
                o_state_next.elapsed_ticks = 16'd0;
                o_result.status            = ST_RUN;
                o_result.maneuver          = choice;
            end
        end else begin
            case (i_state.mode)
                MODE_SIMPLE, MODE_THREE: begin
                    o_result.maneuver          = i_state.mode;
                    o_result.cmd_valid         = 1'b1;
                    o_result.status            = ST_RUN;
                    o_state_next.elapsed_ticks = elapsed_inc;
                    if (timed_out || !i_item.scan_valid) begin
                        o_state_next.mode = MODE_IDLE;
                        o_result.status   = ST_FAIL;
                    end else if (i_state.mode == MODE_SIMPLE) begin
                        if (rear_blocked || i_state.travel_tenths >= {2'b0, safe_x10}) begin
                            o_state_next.mode = MODE_IDLE;
                            o_result.status   = ST_OK;
                        end else begin
                            o_state_next.travel_tenths = travel_sat;
                            o_result.linear_speed      = neg_backup;
                        end
                    end else begin
                        case (i_state.turn_phase)
                            PH_REV_STEER: begin
                                if (rear_blocked ||
                                    i_state.travel_tenths >= {2'b0, safe_x10}) begin
                                    o_state_next.turn_phase    = PH_FWD_STEER;
                                    o_state_next.travel_tenths = 16'd0;
                                end else begin
                                    o_state_next.travel_tenths = travel_sat;
                                    o_result.linear_speed      = neg_turn_spd;
                                    o_result.turn_rate         = -steer_rate;
                                end
                            end
                            PH_FWD_STEER: begin
                                if (front_blocked ||
                                    i_state.travel_tenths >= {3'b0, safe_x5}) begin
                                    o_state_next.turn_phase    = PH_REV_STRAIGHT;
                                    o_state_next.travel_tenths = 16'd0;
                                end else begin
                                    o_state_next.travel_tenths = travel_sat;
                                    o_result.linear_speed      = pos_turn_spd;
                                    o_result.turn_rate         = steer_rate;
                                end
                            end
                            PH_REV_STRAIGHT: begin
                                if (rear_blocked ||
                                    i_state.travel_tenths >= {4'b0, safe_x3}) begin
                                    o_state_next.turn_phase = PH_DONE;
                                end else begin
                                    o_state_next.travel_tenths = travel_sat;
                                    o_result.linear_speed      = neg_turn_spd;
                                end
                            end
                            default: begin
                                o_state_next.mode  = MODE_IDLE;
                                o_result.status    = ST_OK;
                                o_result.cmd_valid = 1'b0;
                            end
                        endcase
                    end
                end
                default: begin
                    o_result.status = ST_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/ackermann_recovery_maneuver_controller_unit.sv]
// Recovery maneuver controller for a car-like robot, top level.
// A result passes through the input register and then the result register.
// Throughput: one item per cycle while the output is not stalled; the one-step core between the two registers sets it.
// Reset (i_rst_n low, synchronous): pipeline empties, registers take their defaults,
// the maneuver state goes idle with zero safe distance, travel and elapsed time.
// Depends on armc_pkg, armc_cfg and armc_core.
module ackermann_recovery_maneuver_controller_unit
    import armc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] scan_valid, [14:1] dist_front, [28:15] dist_rear, [42:29] dist_left,
    // [56:43] dist_right, [63:57] zero
    input  logic [63:0] s_axis_tdata,
    // [0] func
    input  logic        s_axis_tuser,
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [2] cmd_valid, [13:3] linear_speed, [26:14] turn_rate,
    // [28:27] maneuver, [31:29] zero
    output logic [31:0] m_axis_tdata
);

    t_cfg    cfg;
    t_item   in_item;
    t_state  state_next;
    t_result result;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;
    logic    advance;
    logic    in_accept;

    // Registers take a write in every cycle
    assign o_cfg_ready = 1'b1;

    armc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Unpack the input item
    assign in_item.func       = s_axis_tuser;
    assign in_item.scan_valid = s_axis_tdata[0];
    assign in_item.dist_front = s_axis_tdata[14:1];
    assign in_item.dist_rear  = s_axis_tdata[28:15];
    assign in_item.dist_left  = s_axis_tdata[42:29];
    assign in_item.dist_right = s_axis_tdata[56:43];

    // Advance when the result register is free or being drained
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    armc_core u_core (
        .i_item       (r_in),
        .i_state      (r_state),
        .i_cfg        (cfg),
        .o_state_next (state_next),
        .o_result     (result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= in_item;
        end
    end

    // Maneuver state, updated once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode          <= MODE_IDLE;
            r_state.turn_phase    <= PH_REV_STEER;
            r_state.steer_left    <= 1'b0;
            r_state.safe_distance <= 10'd0;
            r_state.travel_tenths <= 16'd0;
            r_state.elapsed_ticks <= 16'd0;
        end else if (advance) begin
            r_state <= state_next;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b0, r_out.maneuver, r_out.turn_rate, r_out.linear_speed,
                            r_out.cmd_valid, r_out.status};

    // A tick while idle reports idle
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.func == FUNC_TICK && r_state.mode == MODE_IDLE
        |=> r_out.status == ST_IDLE && !r_out.cmd_valid)
        else $error("tick in idle mode did not report idle");

    // An active maneuver always holds a clamped safe distance
    a_safe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mode != MODE_IDLE
        |-> r_state.safe_distance >= SAFE_MIN && r_state.safe_distance <= SAFE_MAX)
        else $error("safe distance out of range during a maneuver");

    // Straight reverse never leaves the first phase
    a_simple_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mode == MODE_SIMPLE |-> r_state.turn_phase == PH_REV_STEER)
        else $error("simple reverse left the first phase");

    // No command means zero motion in the result
    a_no_cmd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.cmd_valid
        |-> r_out.linear_speed == 11'sd0 && r_out.turn_rate == 13'sd0)
        else $error("motion values without a command");

endmodule
